FILE: rtl/lbx_pkg.sv
// ---------------------------------------------------------------------------
// lbx_pkg
// Shared types, widths and codes of the letterbox and crop block.
// ---------------------------------------------------------------------------
package lbx_pkg;

    localparam int DIM_W     = 13;
    localparam int EDGE_W    = 14;
    localparam int PAR_W     = 8;
    localparam int VW        = 30;
    localparam int DEN_W     = DIM_W + PAR_W;
    localparam int MUL_A_W   = DEN_W + 1;
    localparam int MUL_B_W   = 16;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_XW    = 36;
    localparam int DIV_YW    = DEN_W + 1;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int MAX_DIM_DEF = 4096;

    localparam logic [DIM_W-1:0] VIDEO_WIDTH_RST  = 13'd720;
    localparam logic [DIM_W-1:0] VIDEO_HEIGHT_RST = 13'd576;
    localparam logic [PAR_W-1:0] PAR_NUM_RST      = 8'd16;
    localparam logic [PAR_W-1:0] PAR_DEN_RST      = 8'd15;

    localparam logic signed [EDGE_W-1:0] SENT_KEEP = -14'sd1;
    localparam logic signed [EDGE_W-1:0] SENT_DFLT = -14'sd2;

    typedef enum logic [1:0] {
        REG_VIDEO_WIDTH  = 2'd0,
        REG_VIDEO_HEIGHT = 2'd1,
        REG_PAR_NUM      = 2'd2,
        REG_PAR_DEN      = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        KIND_NEW_VIDEO  = 2'd0,
        KIND_RESIZE     = 2'd1,
        KIND_CROP_VIDEO = 2'd2,
        KIND_CROP_WIN   = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TV_TRIV,
        OP_TV_MUL1,
        OP_TV_MUL2,
        OP_TV_SUM,
        OP_TV_DIV,
        OP_TV_STORE,
        OP_APPLY,
        OP_PL_MUL1,
        OP_PL_MUL2,
        OP_PL_MUL3,
        OP_PL_DIV1,
        OP_PL_W,
        OP_PL_DIV2,
        OP_PL_H,
        OP_PL_FULL,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] edge_idx;
    } t_cmd;

    typedef struct packed {
        logic crop_win;
        logic trivial;
        logic div_done;
        logic zero_ratio;
        logic dw_fit;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/video_letterbox_and_crop.sv
// ---------------------------------------------------------------------------
// video_letterbox_and_crop
// Crop rectangle and letterbox placement of a video frame in a window.
// ---------------------------------------------------------------------------
// One item is one event (new video, window resize, crop in video pixels or
// crop in window pixels) and yields one result: the placed destination and the
// source crop. Items are handled one at a time; all exact roundings go through
// a single 36-step restoring divider that retires one quotient bit per cycle,
// and that divider sets the latency. A new video, resize or video-pixel crop
// divides once for the fitted width, and once more when the height must be
// fitted instead; a zero ratio skips both. A window-pixel crop adds a division
// for every edge that is mapped back through the placement; a kept or
// defaulted edge needs none. A finished result waits in the output register
// while the next item is accepted.
// Configuration registers sit at byte addresses 0, 4, 8 and 12.
// ---------------------------------------------------------------------------
module video_letterbox_and_crop #(
    parameter int MAX_DIM = lbx_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lbx_pkg::ADDR_W-1:0]        paddr,
    input  logic [lbx_pkg::DATA_W-1:0]        pwdata,
    output logic [lbx_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic [lbx_pkg::DIM_W-1:0]         i_new_win_width,
    input  logic [lbx_pkg::DIM_W-1:0]         i_new_win_height,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_left,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_right,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_top,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_bottom,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lbx_pkg::DIM_W-1:0]         o_dest_x,
    output logic [lbx_pkg::DIM_W-1:0]         o_dest_y,
    output logic [lbx_pkg::DIM_W-1:0]         o_dest_w,
    output logic [lbx_pkg::DIM_W-1:0]         o_dest_h,
    output logic [lbx_pkg::DIM_W-1:0]         o_crop_x,
    output logic [lbx_pkg::DIM_W-1:0]         o_crop_y,
    output logic [lbx_pkg::DIM_W-1:0]         o_crop_w,
    output logic [lbx_pkg::DIM_W-1:0]         o_crop_h,
    output logic                              o_full_frame
);
    import lbx_pkg::*;

    logic [DIM_W-1:0] r_video_width, r_video_height;
    logic [PAR_W-1:0] r_par_num, r_par_den;
    logic             wr_en;
    t_reg             reg_idx;
    t_cmd             cmd;
    t_stat            stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_width  <= VIDEO_WIDTH_RST;
            r_video_height <= VIDEO_HEIGHT_RST;
            r_par_num      <= PAR_NUM_RST;
            r_par_den      <= PAR_DEN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_VIDEO_WIDTH:  r_video_width  <= pwdata[DIM_W-1:0];
                REG_VIDEO_HEIGHT: r_video_height <= pwdata[DIM_W-1:0];
                REG_PAR_NUM:      r_par_num      <= pwdata[PAR_W-1:0];
                REG_PAR_DEN:      r_par_den      <= pwdata[PAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VIDEO_WIDTH:  prdata = DATA_W'(r_video_width);
            REG_VIDEO_HEIGHT: prdata = DATA_W'(r_video_height);
            REG_PAR_NUM:      prdata = DATA_W'(r_par_num);
            REG_PAR_DEN:      prdata = DATA_W'(r_par_den);
            default:          prdata = '0;
        endcase
    end

    lbx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lbx_dp #(
        .MAX_DIM(MAX_DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_video_width   (r_video_width),
        .i_video_height  (r_video_height),
        .i_par_num       (r_par_num),
        .i_par_den       (r_par_den),
        .i_kind          (i_kind),
        .i_new_win_width (i_new_win_width),
        .i_new_win_height(i_new_win_height),
        .i_edge_left     (i_edge_left),
        .i_edge_right    (i_edge_right),
        .i_edge_top      (i_edge_top),
        .i_edge_bottom   (i_edge_bottom),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_dest_x        (o_dest_x),
        .o_dest_y        (o_dest_y),
        .o_dest_w        (o_dest_w),
        .o_dest_h        (o_dest_h),
        .o_crop_x        (o_crop_x),
        .o_crop_y        (o_crop_y),
        .o_crop_w        (o_crop_w),
        .o_crop_h        (o_crop_h),
        .o_full_frame    (o_full_frame)
    );

endmodule

FILE: rtl/lbx_div.sv
// ---------------------------------------------------------------------------
// lbx_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lbx_div #(
    parameter int XW = 36,
    parameter int YW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    output logic          o_done,
    output logic [XW-1:0] o_q
);
    localparam int CW = $clog2(XW + 1);

    logic [YW-1:0] r_rem;
    logic [XW-1:0] r_q;
    logic [YW-1:0] r_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [YW:0]   rem_sh;
    logic [YW:0]   diff;
    logic          ge;

    assign rem_sh = {r_rem, r_q[XW-1]};
    assign ge     = rem_sh >= {1'b0, r_y};
    assign diff   = rem_sh - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(XW);
                r_rem  <= '0;
                r_q    <= i_x;
                r_y    <= i_y;
            end else if (r_busy) begin
                r_rem <= ge ? diff[YW-1:0] : rem_sh[YW-1:0];
                r_q   <= {r_q[XW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

FILE: rtl/lbx_dp.sv
// ---------------------------------------------------------------------------
// lbx_dp
// Datapath: event state, shared multiplier, divider and output register.
// ---------------------------------------------------------------------------
module lbx_dp #(
    parameter int MAX_DIM = lbx_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lbx_pkg::t_cmd                    i_cmd,
    output lbx_pkg::t_stat                   o_stat,
    input  logic [lbx_pkg::DIM_W-1:0]        i_video_width,
    input  logic [lbx_pkg::DIM_W-1:0]        i_video_height,
    input  logic [lbx_pkg::PAR_W-1:0]        i_par_num,
    input  logic [lbx_pkg::PAR_W-1:0]        i_par_den,
    input  logic [1:0]                       i_kind,
    input  logic [lbx_pkg::DIM_W-1:0]        i_new_win_width,
    input  logic [lbx_pkg::DIM_W-1:0]        i_new_win_height,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_left,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_right,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_top,
    input  logic signed [lbx_pkg::EDGE_W-1:0] i_edge_bottom,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [lbx_pkg::DIM_W-1:0]        o_dest_x,
    output logic [lbx_pkg::DIM_W-1:0]        o_dest_y,
    output logic [lbx_pkg::DIM_W-1:0]        o_dest_w,
    output logic [lbx_pkg::DIM_W-1:0]        o_dest_h,
    output logic [lbx_pkg::DIM_W-1:0]        o_crop_x,
    output logic [lbx_pkg::DIM_W-1:0]        o_crop_y,
    output logic [lbx_pkg::DIM_W-1:0]        o_crop_w,
    output logic [lbx_pkg::DIM_W-1:0]        o_crop_h,
    output logic                             o_full_frame
);
    import lbx_pkg::*;

    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] width;
    } t_span;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    // Clamp one axis of a crop to the frame and round it down to even values.
    function automatic t_span clamp_span(input logic signed [VW-1:0] lo,
                                         input logic signed [VW-1:0] hi,
                                         input logic [DIM_W-1:0] f);
        logic signed [VW:0] l;
        logic signed [VW:0] r;
        logic signed [VW:0] fs;
        t_span s;
        fs = $signed((VW+1)'(f));
        l  = lo;
        r  = hi;
        if (l < 0) begin
            l = '0;
        end
        if (l > fs) begin
            l = fs;
        end
        if (r < l + 1) begin
            r = l + 1;
        end
        if (r > fs) begin
            r = fs;
        end
        s.left  = DIM_W'(l) & ~DIM_W'(1);
        s.width = DIM_W'(r - l) & ~DIM_W'(1);
        return s;
    endfunction

    t_kind                    r_kind;
    logic [DIM_W-1:0]         r_nww, r_nwh;
    logic signed [EDGE_W-1:0] r_edge [4];
    logic signed [VW-1:0]     r_vedge [4];
    logic [DIM_W-1:0]         r_win_w, r_win_h;
    logic [DIM_W-1:0]         r_sl, r_st, r_sw, r_sh;
    logic [DIM_W-1:0]         r_pl, r_pt, r_pw, r_ph;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VW-1:0]     r_acc;
    logic [DEN_W-1:0]         r_wden, r_hden;
    logic                     r_dw_fit;
    logic                     r_out_valid;

    logic [DIM_W-1:0]         fw, fh;
    logic                     axis, hi_edge;
    logic signed [EDGE_W-1:0] w_sel;
    logic [DIM_W-1:0]         src_lo, src_len, dst_lo, dst_len, dflt;
    logic [EDGE_W-1:0]        cur;
    logic [MUL_A_W-1:0]       a_u;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [VW-1:0]            acc_mag;
    logic                     div_start, div_done;
    logic [DIV_XW-1:0]        div_x, div_q;
    logic [DIV_YW-1:0]        div_y;
    logic [VW-1:0]            q_v;
    logic signed [VW-1:0]     crop_l, crop_r, crop_t, crop_b;
    t_span                    span_x, span_y;
    logic                     out_free;

    assign fw = sat_dim(i_video_width);
    assign fh = sat_dim(i_video_height);

    // Operands of the edge selected by the controller.
    assign axis    = i_cmd.edge_idx[1];
    assign hi_edge = i_cmd.edge_idx[0];
    assign w_sel   = r_edge[i_cmd.edge_idx];
    assign src_lo  = axis ? r_st : r_sl;
    assign src_len = axis ? r_sh : r_sw;
    assign dst_lo  = axis ? r_pt : r_pl;
    assign dst_len = axis ? r_ph : r_pw;
    assign cur     = EDGE_W'(src_lo) + (hi_edge ? EDGE_W'(src_len) : '0);
    assign dflt    = hi_edge ? (axis ? fh : fw) : '0;

    always_comb begin
        a_u   = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_TV_MUL1: begin
                a_u   = MUL_A_W'(src_lo);
                mul_b = $signed(MUL_B_W'(dst_len));
            end
            OP_TV_MUL2: begin
                a_u   = MUL_A_W'(src_len);
                mul_b = MUL_B_W'(w_sel) - MUL_B_W'(dst_lo);
            end
            OP_PL_MUL1: begin
                a_u   = MUL_A_W'(r_sh);
                mul_b = $signed(MUL_B_W'(i_par_den));
            end
            OP_PL_MUL2: begin
                a_u   = MUL_A_W'(r_sw);
                mul_b = $signed(MUL_B_W'(i_par_num));
            end
            OP_PL_MUL3: begin
                a_u   = MUL_A_W'(r_prod[DEN_W-1:0]);
                mul_b = $signed(MUL_B_W'(r_win_h));
            end
            OP_PL_W: begin
                a_u   = MUL_A_W'(r_wden);
                mul_b = $signed(MUL_B_W'(r_win_w));
            end
            default: begin
                a_u   = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = $signed(a_u) * mul_b;
    assign acc_mag = r_acc[VW-1] ? VW'(-r_acc) : VW'(r_acc);

    always_comb begin
        div_start = 1'b0;
        div_x     = '0;
        div_y     = '0;
        case (i_cmd.op)
            OP_TV_DIV: begin
                div_start = 1'b1;
                div_x     = DIV_XW'({acc_mag, 1'b0}) + DIV_XW'(dst_len);
                div_y     = DIV_YW'({dst_len, 1'b0});
            end
            OP_PL_DIV1: begin
                div_start = 1'b1;
                div_x     = {r_prod[DIV_XW-2:0], 1'b0} + DIV_XW'(r_wden);
                div_y     = {r_wden, 1'b0};
            end
            OP_PL_DIV2: begin
                div_start = 1'b1;
                div_x     = {r_prod[DIV_XW-2:0], 1'b0} + DIV_XW'(r_hden);
                div_y     = {r_hden, 1'b0};
            end
            default: begin
                div_start = 1'b0;
                div_x     = '0;
                div_y     = '0;
            end
        endcase
    end

    lbx_div #(
        .XW(DIV_XW),
        .YW(DIV_YW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_x    (div_x),
        .i_y    (div_y),
        .o_done (div_done),
        .o_q    (div_q)
    );

    assign q_v = div_q[VW-1:0];

    // Crop edges come straight from the item, or from the mapped window edges.
    always_comb begin
        if (r_kind == KIND_CROP_WIN) begin
            crop_l = r_vedge[0];
            crop_r = r_vedge[1];
            crop_t = r_vedge[2];
            crop_b = r_vedge[3];
        end else begin
            crop_l = VW'(r_edge[0]);
            crop_r = VW'(r_edge[1]);
            crop_t = VW'(r_edge[2]);
            crop_b = VW'(r_edge[3]);
        end
    end

    assign span_x   = clamp_span(crop_l, crop_r, fw);
    assign span_y   = clamp_span(crop_t, crop_b, fh);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_NEW_VIDEO;
            r_win_w     <= '0;
            r_win_h     <= '0;
            r_sl        <= '0;
            r_st        <= '0;
            r_sw        <= '0;
            r_sh        <= '0;
            r_pl        <= '0;
            r_pt        <= '0;
            r_pw        <= '0;
            r_ph        <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_kind    <= t_kind'(i_kind);
                    r_nww     <= i_new_win_width;
                    r_nwh     <= i_new_win_height;
                    r_edge[0] <= i_edge_left;
                    r_edge[1] <= i_edge_right;
                    r_edge[2] <= i_edge_top;
                    r_edge[3] <= i_edge_bottom;
                end
                OP_TV_TRIV: begin
                    if (w_sel == SENT_DFLT) begin
                        r_vedge[i_cmd.edge_idx] <= $signed(VW'(dflt));
                    end else begin
                        r_vedge[i_cmd.edge_idx] <= $signed(VW'(cur));
                    end
                end
                OP_TV_MUL1: begin
                    r_prod <= prod;
                end
                OP_TV_MUL2: begin
                    r_acc  <= r_prod[VW-1:0];
                    r_prod <= prod;
                end
                OP_TV_SUM: begin
                    r_acc <= r_acc + r_prod[VW-1:0];
                end
                OP_TV_STORE: begin
                    r_vedge[i_cmd.edge_idx] <= r_acc[VW-1] ? -$signed(q_v) : $signed(q_v);
                end
                OP_APPLY: begin
                    case (r_kind)
                        KIND_NEW_VIDEO: begin
                            r_sl <= '0;
                            r_st <= '0;
                            r_sw <= fw;
                            r_sh <= fh;
                        end
                        KIND_RESIZE: begin
                            r_win_w <= sat_dim(r_nww);
                            r_win_h <= sat_dim(r_nwh);
                        end
                        default: begin
                            r_sl <= span_x.left;
                            r_sw <= span_x.width;
                            r_st <= span_y.left;
                            r_sh <= span_y.width;
                        end
                    endcase
                end
                OP_PL_MUL1: begin
                    r_prod <= prod;
                end
                OP_PL_MUL2: begin
                    r_wden <= r_prod[DEN_W-1:0];
                    r_prod <= prod;
                end
                OP_PL_MUL3: begin
                    r_hden <= r_prod[DEN_W-1:0];
                    r_prod <= prod;
                end
                OP_PL_W: begin
                    r_prod   <= prod;
                    r_dw_fit <= div_q <= DIV_XW'(r_win_w);
                    r_pt     <= '0;
                    r_ph     <= r_win_h;
                    if (div_q <= DIV_XW'(r_win_w)) begin
                        r_pw <= div_q[DIM_W-1:0];
                        r_pl <= (r_win_w - div_q[DIM_W-1:0]) >> 1;
                    end else begin
                        r_pw <= r_win_w;
                        r_pl <= '0;
                    end
                end
                OP_PL_H: begin
                    if (div_q <= DIV_XW'(r_win_h)) begin
                        r_ph <= div_q[DIM_W-1:0];
                        r_pt <= (r_win_h - div_q[DIM_W-1:0]) >> 1;
                    end
                end
                OP_PL_FULL: begin
                    r_pl <= '0;
                    r_pt <= '0;
                    r_pw <= r_win_w;
                    r_ph <= r_win_h;
                end
                OP_OUT: begin
                    o_dest_x     <= r_pl;
                    o_dest_y     <= r_pt;
                    o_dest_w     <= r_pw;
                    o_dest_h     <= r_ph;
                    o_crop_x     <= r_sl;
                    o_crop_y     <= r_st;
                    o_crop_w     <= r_sw;
                    o_crop_h     <= r_sh;
                    o_full_frame <= (r_sl == '0) && (r_st == '0) && (r_sw == fw) && (r_sh == fh);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.crop_win   = r_kind == KIND_CROP_WIN;
    assign o_stat.trivial    = (w_sel == SENT_DFLT) || (w_sel == SENT_KEEP) || (dst_len == '0);
    assign o_stat.div_done   = div_done;
    assign o_stat.zero_ratio = (r_wden == '0) || (r_hden == '0);
    assign o_stat.dw_fit     = r_dw_fit;
    assign o_stat.out_free   = out_free;

endmodule

FILE: rtl/lbx_ctrl.sv
// ---------------------------------------------------------------------------
// lbx_ctrl
// Sequencer that steps the datapath through one event.
// ---------------------------------------------------------------------------
module lbx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lbx_pkg::t_stat i_stat,
    output lbx_pkg::t_cmd  o_cmd
);
    import lbx_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEC,
        S_TV_CHK,
        S_TV_MUL2,
        S_TV_SUM,
        S_TV_DIV,
        S_TV_WAIT,
        S_TV_STORE,
        S_APPLY,
        S_PL_MUL1,
        S_PL_MUL2,
        S_PL_MUL3,
        S_PL_CHK,
        S_PL_WAIT1,
        S_PL_W,
        S_PL_CHK2,
        S_PL_WAIT2,
        S_PL_H,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_edge, n_edge;
    t_op        op;

    always_comb begin
        n_state = r_state;
        n_edge  = r_edge;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                n_edge = '0;
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = i_stat.crop_win ? S_TV_CHK : S_APPLY;
            end
            S_TV_CHK: begin
                if (i_stat.trivial) begin
                    op = OP_TV_TRIV;
                    if (r_edge == 2'd3) begin
                        n_state = S_APPLY;
                    end else begin
                        n_edge = r_edge + 1'b1;
                    end
                end else begin
                    op      = OP_TV_MUL1;
                    n_state = S_TV_MUL2;
                end
            end
            S_TV_MUL2: begin
                op      = OP_TV_MUL2;
                n_state = S_TV_SUM;
            end
            S_TV_SUM: begin
                op      = OP_TV_SUM;
                n_state = S_TV_DIV;
            end
            S_TV_DIV: begin
                op      = OP_TV_DIV;
                n_state = S_TV_WAIT;
            end
            S_TV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_TV_STORE;
                end
            end
            S_TV_STORE: begin
                op = OP_TV_STORE;
                if (r_edge == 2'd3) begin
                    n_state = S_APPLY;
                end else begin
                    n_edge  = r_edge + 1'b1;
                    n_state = S_TV_CHK;
                end
            end
            S_APPLY: begin
                op      = OP_APPLY;
                n_state = S_PL_MUL1;
            end
            S_PL_MUL1: begin
                op      = OP_PL_MUL1;
                n_state = S_PL_MUL2;
            end
            S_PL_MUL2: begin
                op      = OP_PL_MUL2;
                n_state = S_PL_MUL3;
            end
            S_PL_MUL3: begin
                op      = OP_PL_MUL3;
                n_state = S_PL_CHK;
            end
            S_PL_CHK: begin
                if (i_stat.zero_ratio) begin
                    op      = OP_PL_FULL;
                    n_state = S_OUT;
                end else begin
                    op      = OP_PL_DIV1;
                    n_state = S_PL_WAIT1;
                end
            end
            S_PL_WAIT1: begin
                if (i_stat.div_done) begin
                    n_state = S_PL_W;
                end
            end
            S_PL_W: begin
                op      = OP_PL_W;
                n_state = S_PL_CHK2;
            end
            S_PL_CHK2: begin
                // The height division is needed only when the fitted width overflows.
                if (i_stat.dw_fit) begin
                    n_state = S_OUT;
                end else begin
                    op      = OP_PL_DIV2;
                    n_state = S_PL_WAIT2;
                end
            end
            S_PL_WAIT2: begin
                if (i_stat.div_done) begin
                    n_state = S_PL_H;
                end
            end
            S_PL_H: begin
                op      = OP_PL_H;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    op      = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_edge  <= '0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
        end
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_cmd.op       = op;
    assign o_cmd.edge_idx = r_edge;

endmodule

FILE: rtl/lbx_checker.sv
// ---------------------------------------------------------------------------
// lbx_checker
// Port-level checks of the letterbox and crop block, bound to its top level.
// ---------------------------------------------------------------------------
module lbx_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [lbx_pkg::DIM_W-1:0] o_dest_x,
    input logic [lbx_pkg::DIM_W-1:0] o_dest_y,
    input logic [lbx_pkg::DIM_W-1:0] o_dest_w,
    input logic [lbx_pkg::DIM_W-1:0] o_dest_h,
    input logic [lbx_pkg::DIM_W-1:0] o_crop_x,
    input logic [lbx_pkg::DIM_W-1:0] o_crop_y,
    input logic [lbx_pkg::DIM_W-1:0] o_crop_w,
    input logic [lbx_pkg::DIM_W-1:0] o_crop_h,
    input logic                      o_full_frame
);

    // A stalled result item stays valid, with its destination, crop x and crop width held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dest_x) &&
        $stable(o_dest_y) && $stable(o_dest_w) && $stable(o_dest_h) &&
        $stable(o_crop_x) && $stable(o_crop_w))
        else $error("result item changed while stalled");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in work");

    // A full-frame crop starts at the frame origin.
    a_full_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_frame |-> o_crop_x == '0 && o_crop_y == '0)
        else $error("full frame flagged with a shifted crop");

    // A crop that is not at the origin is placed on even pixels.
    a_even_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_crop_x[0] && !o_crop_y[0])
        else $error("crop origin is odd");

endmodule

bind video_letterbox_and_crop lbx_checker u_lbx_checker (.*);

FILE: dv/video_letterbox_and_crop_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// video_letterbox_and_crop_tb
// Self-checking bench for the letterbox placement and crop block.
// ---------------------------------------------------------------------------
// Events are queued by the stimulus process and driven in random bursts. An
// in-bench placement predictor computes the expected destination and crop
// for each accepted item. The monitor checks results against that queue
// while the receiver stalls on its own pattern. Configuration changes happen
// only while the block is idle.
// ---------------------------------------------------------------------------
module video_letterbox_and_crop_tb;
    import lbx_pkg::*;

    localparam int MAXD = 4096;

    typedef struct packed {
        logic [1:0]        kind;
        logic [12:0]       nww;
        logic [12:0]       nwh;
        logic signed [13:0] el;
        logic signed [13:0] er;
        logic signed [13:0] et;
        logic signed [13:0] eb;
    } t_event;

    typedef struct packed {
        logic [12:0] dx, dy, dw, dh, cx, cy, cw, ch;
        logic        full;
    } t_place;

    logic i_clk = 0, i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 0, o_in_stall;
    logic [1:0] i_kind = '0;
    logic [12:0] i_new_win_width = '0, i_new_win_height = '0;
    logic signed [13:0] i_edge_left = '0, i_edge_right = '0, i_edge_top = '0;
    logic signed [13:0] i_edge_bottom = '0;
    logic o_out_valid, i_out_stall = 0;
    logic [12:0] o_dest_x, o_dest_y, o_dest_w, o_dest_h;
    logic [12:0] o_crop_x, o_crop_y, o_crop_w, o_crop_h;
    logic o_full_frame;

    video_letterbox_and_crop uut (.*);

    // Predictor state.
    longint vid_w = 720, vid_h = 576, pnum = 16, pden = 15;
    longint win_w, win_h, src_l, src_t, src_w, src_h, pl_l, pl_t, pl_w, pl_h;

    t_event pending_events[$];
    t_place expected_places[$];
    int errors = 0, n_items = 0, n_results = 0, n_cfg = 0;
    bit sender_hold = 0;
    bit in_taken = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic void queue_event(t_event e);
        pending_events = {pending_events, e};
    endfunction

    function automatic longint sat_dim(longint v);
        return v > MAXD ? MAXD : v;
    endfunction

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic void fit_window();
        longint wden, hden, fw_, fh_;
        wden = pden * src_h;
        hden = pnum * src_w;
        pl_l = 0; pl_t = 0; pl_w = win_w; pl_h = win_h;
        if (wden != 0 && hden != 0) begin
            fw_ = round_div(pnum * src_w * win_h, wden);
            fh_ = round_div(win_w * pden * src_h, hden);
            if (fw_ <= win_w) begin
                pl_w = fw_;
                pl_l = (win_w - fw_) >> 1;
            end else if (fh_ <= win_h) begin
                pl_h = fh_;
                pl_t = (win_h - fh_) >> 1;
            end
        end
    endfunction

    function automatic void apply_crop(longint l, longint r, longint t, longint b);
        longint fw, fh;
        fw = sat_dim(vid_w);
        fh = sat_dim(vid_h);
        l = clampv(l, 0, fw);
        r = clampv(r, l + 1, fw);
        t = clampv(t, 0, fh);
        b = clampv(b, t + 1, fh);
        if (r < l) r = l;
        if (b < t) b = t;
        src_l = l & ~64'd1;
        src_w = (r - l) & ~64'd1;
        src_t = t & ~64'd1;
        src_h = (b - t) & ~64'd1;
    endfunction

    function automatic longint win_to_video(longint w, longint cur, longint dflt,
            longint slo, longint slen, longint dlo, longint dlen);
        if (w == SENT_DFLT) return dflt;
        if (w == SENT_KEEP) return cur;
        if (dlen == 0) return cur;
        return round_div(slo * dlen + slen * (w - dlo), dlen);
    endfunction

    function automatic t_place predict_placement(t_event e);
        longint fw, fh, l, r, t, b, vl, vr, vt, vb;
        t_place p;
        fw = sat_dim(vid_w);
        fh = sat_dim(vid_h);
        l = e.el; r = e.er; t = e.et; b = e.eb;
        case (t_kind'(e.kind))
            KIND_NEW_VIDEO: begin
                src_l = 0; src_t = 0; src_w = fw; src_h = fh;
            end
            KIND_RESIZE: begin
                win_w = sat_dim(e.nww);
                win_h = sat_dim(e.nwh);
            end
            KIND_CROP_VIDEO: apply_crop(l, r, t, b);
            default: begin
                vl = win_to_video(l, src_l, 0, src_l, src_w, pl_l, pl_w);
                vr = win_to_video(r, src_l + src_w, fw, src_l, src_w, pl_l, pl_w);
                vt = win_to_video(t, src_t, 0, src_t, src_h, pl_t, pl_h);
                vb = win_to_video(b, src_t + src_h, fh, src_t, src_h, pl_t, pl_h);
                apply_crop(vl, vr, vt, vb);
            end
        endcase
        fit_window();
        p.dx = 13'(pl_l); p.dy = 13'(pl_t); p.dw = 13'(pl_w); p.dh = 13'(pl_h);
        p.cx = 13'(src_l); p.cy = 13'(src_t); p.cw = 13'(src_w); p.ch = 13'(src_h);
        p.full = (src_l == 0 && src_t == 0 && src_w == fw && src_h == fh);
        return p;
    endfunction

    // An item is taken at the rising edge; the driver sees it at the next falling edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // Driver: bursts of items separated by random gaps.
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                expected_places = {expected_places,
                                   predict_placement(pending_events.pop_front())};
                n_items++;
            end
            if (!i_in_valid || in_taken) begin
                if (gap_left > 0) gap_left--;
                if (pending_events.size() > 0 && gap_left == 0 && !sender_hold) begin
                    i_in_valid <= 1;
                    {i_kind, i_new_win_width, i_new_win_height, i_edge_left,
                     i_edge_right, i_edge_top, i_edge_bottom} <= pending_events[0];
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                    end else burst_left--;
                end else i_in_valid <= 0;
            end
        end
    end

    // Receiver stall pattern: alternating calm and busy phases.
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase = (stall_phase + 1) % 3000;
        if (stall_phase < 1000) i_out_stall <= 0;
        else i_out_stall <= ($urandom_range(0, 99) < 60);
    end

    always @(posedge i_clk) begin
        t_place got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_dest_x, o_dest_y, o_dest_w, o_dest_h, o_crop_x, o_crop_y,
                   o_crop_w, o_crop_h, o_full_frame};
            n_results++;
            if (expected_places.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
            end else begin
                want = expected_places.pop_front();
                if (got.dx != want.dx) begin $error("dest_x exp %0d got %0d", want.dx, got.dx); errors++; end
                if (got.dy != want.dy) begin $error("dest_y exp %0d got %0d", want.dy, got.dy); errors++; end
                if (got.dw != want.dw) begin $error("dest_w exp %0d got %0d", want.dw, got.dw); errors++; end
                if (got.dh != want.dh) begin $error("dest_h exp %0d got %0d", want.dh, got.dh); errors++; end
                if (got.cx != want.cx) begin $error("crop_x exp %0d got %0d", want.cx, got.cx); errors++; end
                if (got.cy != want.cy) begin $error("crop_y exp %0d got %0d", want.cy, got.cy); errors++; end
                if (got.cw != want.cw) begin $error("crop_w exp %0d got %0d", want.cw, got.cw); errors++; end
                if (got.ch != want.ch) begin $error("crop_h exp %0d got %0d", want.ch, got.ch); errors++; end
                if (got.full != want.full) begin
                    $error("full_frame exp %0d got %0d", want.full, got.full);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_events.size() > 0 || i_in_valid || expected_places.size() > 0)
            @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [DATA_W-1:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_W'({r, 2'b00}); pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (r)
            REG_VIDEO_WIDTH:  vid_w = v & 13'h1fff;
            REG_VIDEO_HEIGHT: vid_h = v & 13'h1fff;
            REG_PAR_NUM:      pnum = v & 8'hff;
            default:          pden = v & 8'hff;
        endcase
        n_cfg++;
    endtask

    function automatic logic signed [13:0] rand_edge(int span);
        int s;
        s = $urandom_range(0, 19);
        if (s == 0) return SENT_KEEP;
        if (s == 1) return SENT_DFLT;
        if (s == 2) return 14'($urandom_range(0, 4096));
        if (s == 3) return 14'($urandom);
        return 14'($urandom_range(0, span));
    endfunction

    function automatic t_event make_event(t_kind k, int nw, int nh, int l, int r,
            int t, int b);
        t_event e;
        e.kind = k; e.nww = 13'(nw); e.nwh = 13'(nh);
        e.el = 14'(l); e.er = 14'(r); e.et = 14'(t); e.eb = 14'(b);
        return e;
    endfunction

    function automatic t_event rand_event();
        t_event e;
        int span;
        span = $urandom_range(0, 1) ? 1200 : 4096;
        e.kind = 2'($urandom_range(0, 3));
        e.nww = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 2000));
        e.nwh = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 2000));
        e.el = rand_edge(span); e.er = rand_edge(span);
        e.et = rand_edge(span); e.eb = rand_edge(span);
        return e;
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // Directed: crop before any window, extremes, sentinels, zero sizes.
        queue_event(make_event(KIND_CROP_WIN, 0, 0, -1, -2, -1, -2));
        queue_event(make_event(KIND_NEW_VIDEO, 0, 0, 0, 0, 0, 0));
        queue_event(make_event(KIND_RESIZE, 1920, 1080, 0, 0, 0, 0));
        queue_event(make_event(KIND_RESIZE, 8191, 8191, 0, 0, 0, 0));
        queue_event(make_event(KIND_RESIZE, 800, 1200, 0, 0, 0, 0));
        queue_event(make_event(KIND_CROP_VIDEO, 0, 0, 11, 700, 33, 501));
        queue_event(make_event(KIND_CROP_VIDEO, 0, 0, -2, -1, -1, -2));
        queue_event(make_event(KIND_CROP_VIDEO, 0, 0, 719, 719, 575, 4096));
        queue_event(make_event(KIND_CROP_VIDEO, 0, 0, 8191, -8192, 4096, 0));
        queue_event(make_event(KIND_CROP_WIN, 0, 0, 10, -1, -2, 300));
        queue_event(make_event(KIND_CROP_WIN, 0, 0, -2, -2, -2, -2));
        queue_event(make_event(KIND_CROP_WIN, 0, 0, -8192, 8191, 100, -100));
        queue_event(make_event(KIND_RESIZE, 0, 0, 0, 0, 0, 0));
        queue_event(make_event(KIND_CROP_WIN, 0, 0, 5, 6, 7, 8));
        queue_event(make_event(KIND_RESIZE, 1, 4096, 0, 0, 0, 0));
        queue_event(make_event(KIND_NEW_VIDEO, 0, 0, 0, 0, 0, 0));
        wait_idle();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_VIDEO_WIDTH, 4096); write_reg(REG_VIDEO_HEIGHT, 1);
                          write_reg(REG_PAR_NUM, 255); write_reg(REG_PAR_DEN, 1); end
                1: begin write_reg(REG_VIDEO_WIDTH, 1); write_reg(REG_VIDEO_HEIGHT, 8191);
                          write_reg(REG_PAR_NUM, 1); write_reg(REG_PAR_DEN, 255); end
                2: begin write_reg(REG_VIDEO_WIDTH, 32'hffff_e000 | 13'd1920);
                          write_reg(REG_VIDEO_HEIGHT, 1080);
                          write_reg(REG_PAR_NUM, 0); write_reg(REG_PAR_DEN, 1); end
                3: begin write_reg(REG_VIDEO_WIDTH, 0); write_reg(REG_VIDEO_HEIGHT, 576);
                          write_reg(REG_PAR_NUM, 1); write_reg(REG_PAR_DEN, 0); end
                default: begin
                    write_reg(REG_VIDEO_WIDTH, $urandom_range(1, 8191));
                    write_reg(REG_VIDEO_HEIGHT, $urandom_range(1, 8191));
                    write_reg(REG_PAR_NUM, $urandom_range(0, 255));
                    write_reg(REG_PAR_DEN, $urandom_range(0, 255));
                end
            endcase
            queue_event(make_event(KIND_NEW_VIDEO, 0, 0, 0, 0, 0, 0));
            queue_event(make_event(KIND_RESIZE, $urandom_range(1, 2000),
                                   $urandom_range(1, 2000), 0, 0, 0, 0));
            for (int i = 0; i < 180; i++) queue_event(rand_event());
            // Hold the sender halfway until the block drains.
            while (pending_events.size() > 90) @(negedge i_clk);
            sender_hold = 1;
            while (i_in_valid || expected_places.size() > 0) @(negedge i_clk);
            sender_hold = 0;
            wait_idle();
        end
        $display("Ran %0d events and %0d results across %0d register writes,", n_items,
                 n_results, n_cfg);
        $display("covering all event kinds, edge sentinels and ratio extremes.");
        if (errors == 0)
            $display("** video_letterbox_and_crop: PASSED **");
        else
            $display("** video_letterbox_and_crop: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** video_letterbox_and_crop: FAILED **");
        $finish;
    end
endmodule

FILE: files.f
rtl/lbx_pkg.sv
rtl/lbx_div.sv
rtl/lbx_dp.sv
rtl/lbx_ctrl.sv
rtl/video_letterbox_and_crop.sv
rtl/lbx_checker.sv
dv/video_letterbox_and_crop_tb.sv
